// ----- rtl/core/wrle_pkg.sv -----
// Shared types and constants of the word run-length encoder.
// Used by the controller, the datapath and the top level; depends on nothing.

package wrle_pkg;

   // Code ranges of the three run classes
   localparam logic [7:0]  LIT_FIRST    = 8'd0;
   localparam logic [7:0]  ZERO_FIRST   = 8'd128;
   localparam logic [7:0]  ZERO_LAST    = 8'd232;
   localparam logic [7:0]  FILL_FIRST   = 8'd233;
   localparam logic [7:0]  FILL_LAST    = 8'd255;
   localparam logic [31:0] FILLER_RESET = 32'h7040_0101;
   localparam logic [2:0]  GROUP_WORDS  = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_READ,
      ST_EMIT
   } wrle_state_type;

   // Controller to datapath
   typedef struct packed {
      logic take_in;     // apply the incoming word to the open run
      logic hold_in;     // park the incoming word until the old run is sent
      logic take_pend;   // apply the parked word as a fresh run
      logic flush_init;  // rewind the read pointer and group counters
      logic rd_issue;    // read the next literal word from the store
      logic emit;        // load the output register
      logic eos;         // mark the emitted item as end of stream
   } wrle_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic need_flush;      // incoming word cannot join the open run
      logic run_lit;         // open run is a literal run
      logic grp_last_issue;  // this read completes the current group
      logic run_done;        // the group to emit is the last of the run
      logic out_free;        // output register can take an item
      logic pend_last;       // parked word was marked last
   } wrle_sts_type;

endpackage

// ----- rtl/core/wrle_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.

module wrle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/wrle_ctrl.sv -----
// Sequencer of the word run-length encoder: accepts words, orders run flushes.
// Depends on wrle_pkg for the state, command and status types.

module wrle_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_tlast,
   input  wrle_pkg::wrle_sts_type sts,
   output wrle_pkg::wrle_cmd_type cmd
);

   wrle_pkg::wrle_state_type state_ff, state_in;
   logic fin_ff, fin_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wrle_pkg::ST_IDLE;
         fin_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         fin_ff   <= fin_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      fin_in     = fin_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         wrle_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (sts.need_flush) begin
                  // send the old run first, the word waits
                  cmd.hold_in = 1'b1;
                  fin_in      = 1'b0;
                  state_in    = wrle_pkg::ST_START;
               end else begin
                  cmd.take_in = 1'b1;
                  if (req_tlast) begin
                     fin_in   = 1'b1;
                     state_in = wrle_pkg::ST_START;
                  end
               end
            end
         end
         wrle_pkg::ST_START: begin
            cmd.flush_init = 1'b1;
            state_in = sts.run_lit ? wrle_pkg::ST_READ : wrle_pkg::ST_EMIT;
         end
         wrle_pkg::ST_READ: begin
            cmd.rd_issue = 1'b1;
            if (sts.grp_last_issue) begin
               state_in = wrle_pkg::ST_EMIT;
            end
         end
         wrle_pkg::ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.eos  = fin_ff & sts.run_done;
               if (!sts.run_done) begin
                  state_in = wrle_pkg::ST_READ;
               end else if (fin_ff) begin
                  fin_in   = 1'b0;
                  state_in = wrle_pkg::ST_IDLE;
               end else begin
                  cmd.take_pend = 1'b1;
                  if (sts.pend_last) begin
                     fin_in   = 1'b1;
                     state_in = wrle_pkg::ST_START;
                  end else begin
                     state_in = wrle_pkg::ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = wrle_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/core/wrle_dpath.sv -----
// Datapath of the word run-length encoder: run state, literal store, group
// assembly and output register. Depends on wrle_pkg and wrle_ram.

module wrle_dpath #(
   parameter int LITERAL_RUN_MAX = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [31:0]            csr_wr_data,
   input  logic [31:0]            req_word,
   input  logic                   req_last,
   input  wrle_pkg::wrle_cmd_type cmd,
   output wrle_pkg::wrle_sts_type sts,
   input  logic                   rsp_tready,
   output logic                   rsp_tvalid,
   output logic                   rsp_has_code,
   output logic [7:0]             rsp_run_code,
   output logic [2:0]             rsp_word_count,
   output logic [31:0]            rsp_word_a,
   output logic [31:0]            rsp_word_b,
   output logic [31:0]            rsp_word_c,
   output logic [31:0]            rsp_word_d,
   output logic                   rsp_end_of_run,
   output logic                   rsp_end_of_stream
);

   localparam int AW = (LITERAL_RUN_MAX > 1) ? $clog2(LITERAL_RUN_MAX) : 1;
   localparam logic [7:0] LIT_LAST = 8'(LITERAL_RUN_MAX - 1);

   logic [31:0]   filler_ff;
   logic          run_open_ff;
   logic [7:0]    code_ff;
   logic [31:0]   pend_word_ff;
   logic          pend_last_ff;
   logic [AW-1:0] rd_ptr_ff;
   logic [2:0]    grp_cnt_ff;
   logic          first_grp_ff;
   logic          last_issued_ff;
   logic          cap_vld_ff;
   logic [1:0]    cap_slot_ff;
   logic [31:0]   buf_ff [4];
   logic          rsp_tvalid_ff;

   logic [7:0]  req_first, req_limit, app_first, app_limit, code_in;
   logic        req_ext, app_lit, ram_we;
   logic [31:0] app_word, rd_data;
   logic [31:0] view [4];
   logic [31:0] out_word [4];
   logic        run_done;

   // Class of the incoming word: the zero test wins over the filler test
   always_comb begin
      priority if (req_word == 32'd0) begin
         req_first = wrle_pkg::ZERO_FIRST;
         req_limit = wrle_pkg::ZERO_LAST;
      end else if (req_word == filler_ff) begin
         req_first = wrle_pkg::FILL_FIRST;
         req_limit = wrle_pkg::FILL_LAST;
      end else begin
         req_first = wrle_pkg::LIT_FIRST;
         req_limit = LIT_LAST;
      end
   end

   assign req_ext = run_open_ff && (code_ff >= req_first) && (code_ff < req_limit);

   assign app_word = cmd.take_pend ? pend_word_ff : req_word;

   always_comb begin
      priority if (app_word == 32'd0) begin
         app_first = wrle_pkg::ZERO_FIRST;
         app_limit = wrle_pkg::ZERO_LAST;
      end else if (app_word == filler_ff) begin
         app_first = wrle_pkg::FILL_FIRST;
         app_limit = wrle_pkg::FILL_LAST;
      end else begin
         app_first = wrle_pkg::LIT_FIRST;
         app_limit = LIT_LAST;
      end
   end

   assign app_lit = (app_first == wrle_pkg::LIT_FIRST) && (app_limit == LIT_LAST);
   assign code_in = (cmd.take_in && req_ext) ? 8'(code_ff + 8'd1) : app_first;
   assign ram_we  = (cmd.take_in || cmd.take_pend) && app_lit;

   wrle_ram #(
      .WIDTH (32),
      .DEPTH (LITERAL_RUN_MAX)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (code_in[AW-1:0]),
      .wr_data (app_word),
      .rd_en   (cmd.rd_issue),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         filler_ff <= wrle_pkg::FILLER_RESET;
      end else if (csr_wr_en) begin
         filler_ff <= csr_wr_data;
      end
   end

   // Run state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff <= 1'b0;
         code_ff     <= 8'd0;
      end else if (cmd.take_in || cmd.take_pend) begin
         run_open_ff <= 1'b1;
         code_ff     <= code_in;
      end else if (cmd.emit && run_done) begin
         run_open_ff <= 1'b0;
         code_ff     <= 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.hold_in) begin
         pend_word_ff <= req_word;
         pend_last_ff <= req_last;
      end
   end

   // Read sequencing and group assembly
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff      <= '0;
         grp_cnt_ff     <= 3'd0;
         first_grp_ff   <= 1'b0;
         last_issued_ff <= 1'b0;
         cap_vld_ff     <= 1'b0;
      end else begin
         cap_vld_ff <= cmd.rd_issue;
         if (cmd.flush_init) begin
            rd_ptr_ff      <= '0;
            grp_cnt_ff     <= 3'd0;
            first_grp_ff   <= 1'b1;
            last_issued_ff <= 1'b0;
         end else if (cmd.rd_issue) begin
            rd_ptr_ff  <= AW'(rd_ptr_ff + 1'b1);
            grp_cnt_ff <= 3'(grp_cnt_ff + 3'd1);
            if (rd_ptr_ff == code_ff[AW-1:0]) begin
               last_issued_ff <= 1'b1;
            end
         end else if (cmd.emit) begin
            grp_cnt_ff   <= 3'd0;
            first_grp_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         cap_slot_ff <= grp_cnt_ff[1:0];
      end
      if (cap_vld_ff) begin
         buf_ff[cap_slot_ff] <= rd_data;
      end
   end

   // Forward the word still on its way from the store
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         view[i]     = (cap_vld_ff && (cap_slot_ff == 2'(i))) ? rd_data : buf_ff[i];
         out_word[i] = (3'(i) < grp_cnt_ff) ? view[i] : 32'd0;
      end
   end

   assign run_done = !(code_ff <= wrle_pkg::ZERO_FIRST - 8'd1) || last_issued_ff;

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_has_code      <= first_grp_ff;
         rsp_run_code      <= first_grp_ff ? code_ff : 8'd0;
         rsp_word_count    <= grp_cnt_ff;
         rsp_word_a        <= out_word[0];
         rsp_word_b        <= out_word[1];
         rsp_word_c        <= out_word[2];
         rsp_word_d        <= out_word[3];
         rsp_end_of_run    <= run_done;
         rsp_end_of_stream <= cmd.eos;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;

   assign sts.need_flush     = run_open_ff && !req_ext;
   assign sts.run_lit        = (code_ff <= wrle_pkg::ZERO_FIRST - 8'd1);
   assign sts.grp_last_issue = (grp_cnt_ff == wrle_pkg::GROUP_WORDS - 3'd1) ||
                               (rd_ptr_ff == code_ff[AW-1:0]);
   assign sts.run_done       = run_done;
   assign sts.out_free       = !rsp_tvalid_ff || rsp_tready;
   assign sts.pend_last      = pend_last_ff;

endmodule

// ----- rtl/core/word_run_length_encoder.sv -----
// Top level of the word run-length encoder: stream ports and packing.
// Depends on wrle_pkg, wrle_ctrl, wrle_dpath (and wrle_ram below it).
//
// Use: feed 32-bit image words on the req_ channel in address order, with
// req_tlast on the final word. Each run of zero words, filler words
// (csr_wr_data sets the filler; reset value 0x70400101) or other words is
// sent on the rsp_ channel as one code byte; a literal run follows its code
// with its words, four to an item at most.
// Throughput: words that join the open run are taken back to back, so runs
// stream at one word per cycle. A word that closes a run holds req_tready
// low while the run is sent; a literal run is read through the single
// read port of the literal store, one word per cycle within a group.
// After a word marked last the open run is sent the same way.
// Flush: the controller passes START, then READ for a literal run, then
// EMIT, which loads the output register.
// Reset: synchronous; no run is open, the filler returns to its reset value,
// and the output register empties. The literal store is not cleared.
// Stall: a full output register with rsp_tready low holds the flush; the
// item waiting there does not block taking words that extend a run.

module word_run_length_encoder #(
   parameter int LITERAL_RUN_MAX = 128
) (
   input  logic         clock,
   input  logic         reset,
   // filler word register
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data,
   // input words
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // [31:0] data_word
   input  logic         req_tlast,   // last_word
   // coded items
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [7:0] run_code, [10:8] word_count, [42:11] word_a, [74:43] word_b,
   // [106:75] word_c, [138:107] word_d, [143:139] zero
   output logic [143:0] rsp_tdata,
   output logic [1:0]   rsp_tuser,   // [0] has_code, [1] end_of_run
   output logic         rsp_tlast    // end_of_stream
);

   wrle_pkg::wrle_cmd_type cmd;
   wrle_pkg::wrle_sts_type sts;

   logic        rsp_has_code, rsp_end_of_run, rsp_end_of_stream;
   logic [7:0]  rsp_run_code;
   logic [2:0]  rsp_word_count;
   logic [31:0] rsp_word_a, rsp_word_b, rsp_word_c, rsp_word_d;

   // Sequencer: decide when to take a word, flush a run and emit an item
   wrle_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Run state, literal store and output register
   wrle_dpath #(
      .LITERAL_RUN_MAX (LITERAL_RUN_MAX)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_word          (req_tdata),
      .req_last          (req_tlast),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_tready        (rsp_tready),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_has_code      (rsp_has_code),
      .rsp_run_code      (rsp_run_code),
      .rsp_word_count    (rsp_word_count),
      .rsp_word_a        (rsp_word_a),
      .rsp_word_b        (rsp_word_b),
      .rsp_word_c        (rsp_word_c),
      .rsp_word_d        (rsp_word_d),
      .rsp_end_of_run    (rsp_end_of_run),
      .rsp_end_of_stream (rsp_end_of_stream)
   );

   // Pack the item, lowest field first, padded to whole bytes
   assign rsp_tdata = {5'd0, rsp_word_d, rsp_word_c, rsp_word_b, rsp_word_a,
                       rsp_word_count, rsp_run_code};
   assign rsp_tuser = {rsp_end_of_run, rsp_has_code};
   assign rsp_tlast = rsp_end_of_stream;

   // Never overwrite an item still waiting at the output
   a_emit_free : assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("item loaded into a full output register");

   // The store is never read while a word is being written into it
   a_no_rd_on_apply : assert property (@(posedge clock) disable iff (reset)
      cmd.rd_issue |-> !(cmd.take_in || cmd.take_pend))
      else $error("store read while the run is updated");

   // End of stream only on the closing item of a run
   a_eos_closes_run : assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.eos) |-> sts.run_done)
      else $error("end of stream before the run is complete");

   // A parked word blocks further input until its run is handled
   a_hold_blocks : assert property (@(posedge clock) disable iff (reset)
      cmd.hold_in |=> !req_tready)
      else $error("input taken while a word is parked");

endmodule

// ----- tb/sv/word_run_length_encoder_tb.sv -----
// Self-checking bench for word_run_length_encoder: directed table, then random streams.
// Depends on wrle_pkg and the encoder RTL; results are checked against an in-bench model.

module word_run_length_encoder_tb;

   localparam int          LITERAL_RUN_MAX = 128;
   localparam logic [7:0]  LIT_LIMIT       = 8'(LITERAL_RUN_MAX - 1);
   localparam int          PHASES          = 4;
   localparam int          PHASE_ITEMS     = 20;

   // Word classes the stream generator can ask for; RUN_MIXED draws from all of them
   typedef enum int {
      RUN_ZERO,
      RUN_FILLER,
      RUN_LITERAL,
      RUN_MIXED
   } run_kind_type;

   // One coded item as it leaves the encoder
   typedef struct packed {
      logic             has_code;
      logic [7:0]       run_code;
      logic [2:0]       word_count;
      logic [3:0][31:0] words;          // words[0] is word_a
      logic             end_of_run;
      logic             end_of_stream;
   } coded_item_type;

   // One row of the directed table; typed rows carry their expected item
   typedef struct {
      logic [31:0]    word;
      logic           last;
      bit             typed;
      coded_item_type item;
   } stim_row_type;

   logic          clock;
   logic          reset;
   logic          csr_wr_en;
   logic [31:0]   csr_wr_data;
   logic          req_tvalid;
   logic          req_tready;
   logic [31:0]   req_tdata;
   logic          req_tlast;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [143:0]  rsp_tdata;
   logic [1:0]    rsp_tuser;
   logic          rsp_tlast;

   // Encoder model state
   logic [31:0]   filler_model;
   bit            run_active;
   logic [7:0]    run_code_now;
   logic [31:0]   run_words [LITERAL_RUN_MAX];

   coded_item_type run_items [$];       // items caused by the word just taken
   coded_item_type awaited_items [$];   // items still to come from the encoder
   stim_row_type   directed_rows [$];

   int            failures;
   int            items_sent;
   bit            steady;              // suppress idling on both sides

   word_run_length_encoder #(
      .LITERAL_RUN_MAX (LITERAL_RUN_MAX)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Encoder model
   // ---------------------------------------------------------------------

   // Send the open run: one item for zero and filler runs, groups of four
   // words for a literal run with the code on the first group only.
   function automatic void close_open_run();
      coded_item_type it;
      int             total;
      int             pos;
      int             cnt;
      if (!run_active) return;
      if (run_code_now <= LIT_LIMIT) begin
         total = int'(run_code_now) + 1;
         pos   = 0;
         while (pos < total) begin
            cnt           = (total - pos > 4) ? 4 : total - pos;
            it            = '0;
            it.has_code   = (pos == 0);
            it.run_code   = (pos == 0) ? run_code_now : 8'd0;
            it.word_count = 3'(cnt);
            for (int i = 0; i < cnt; i++) it.words[i] = run_words[pos + i];
            it.end_of_run = (pos + cnt == total);
            run_items.push_back(it);
            pos += cnt;
         end
      end else begin
         it            = '0;
         it.has_code   = 1'b1;
         it.run_code   = run_code_now;
         it.end_of_run = 1'b1;
         run_items.push_back(it);
      end
      run_active   = 0;
      run_code_now = 8'd0;
   endfunction

   // Class the word, extend or replace the open run, flush after a last word
   function automatic void encode_word(logic [31:0] w, logic last);
      logic [7:0] first;
      logic [7:0] limit;
      if (w == 32'd0) begin
         first = wrle_pkg::ZERO_FIRST;
         limit = wrle_pkg::ZERO_LAST;
      end else if (w == filler_model) begin
         first = wrle_pkg::FILL_FIRST;
         limit = wrle_pkg::FILL_LAST;
      end else begin
         first = wrle_pkg::LIT_FIRST;
         limit = LIT_LIMIT;
      end
      if (run_active && run_code_now >= first && run_code_now < limit) begin
         run_code_now++;
      end else begin
         close_open_run();
         run_active   = 1;
         run_code_now = first;
      end
      if (first == wrle_pkg::LIT_FIRST) run_words[run_code_now[6:0]] = w;
      if (last) begin
         close_open_run();
         if (run_items.size() > 0) run_items[run_items.size() - 1].end_of_stream = 1'b1;
      end
   endfunction

   // Single-item run closed by a last word; used for the typed table rows
   function automatic coded_item_type lone_run(logic [7:0] code, logic [2:0] cnt,
                                               logic [31:0] w);
      coded_item_type it;
      it               = '0;
      it.has_code      = 1'b1;
      it.run_code      = code;
      it.word_count    = cnt;
      it.words[0]      = w;
      it.end_of_run    = 1'b1;
      it.end_of_stream = 1'b1;
      return it;
   endfunction

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------

   task automatic report(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      failures++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
   endtask

   // Sample each accepted item at the rising edge and compare with the oldest expectation
   always @(posedge clock) begin
      coded_item_type got;
      coded_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.run_code      = rsp_tdata[7:0];
         got.word_count    = rsp_tdata[10:8];
         got.words[0]      = rsp_tdata[42:11];
         got.words[1]      = rsp_tdata[74:43];
         got.words[2]      = rsp_tdata[106:75];
         got.words[3]      = rsp_tdata[138:107];
         got.has_code      = rsp_tuser[0];
         got.end_of_run    = rsp_tuser[1];
         got.end_of_stream = rsp_tlast;
         if (awaited_items.size() == 0) begin
            report($sformatf("item with nothing expected, code %h", got.run_code));
         end else begin
            want = awaited_items.pop_front();
            check_field("has_code",      32'(got.has_code),      32'(want.has_code));
            check_field("run_code",      32'(got.run_code),      32'(want.run_code));
            check_field("word_count",    32'(got.word_count),    32'(want.word_count));
            check_field("word_a",        got.words[0],           want.words[0]);
            check_field("word_b",        got.words[1],           want.words[1]);
            check_field("word_c",        got.words[2],           want.words[2]);
            check_field("word_d",        got.words[3],           want.words[3]);
            check_field("end_of_run",    32'(got.end_of_run),    32'(want.end_of_run));
            check_field("end_of_stream", 32'(got.end_of_stream), 32'(want.end_of_stream));
         end
      end
   end

   // Stall the result side at random, about 9 percent of the time, never while steady
   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 9);
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   // Offer one word, idling at random first; queue its items once taken
   task automatic send_word(logic [31:0] w, logic last, bit typed = 0,
                            coded_item_type item = '0);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 9) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      run_items.delete();
      encode_word(w, last);
      if (typed) awaited_items.push_back(item);
      else foreach (run_items[i]) awaited_items.push_back(run_items[i]);
   endtask

   // Hold the sender until every awaited item has arrived
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (awaited_items.size() != 0) @(posedge clock);
   endtask

   task automatic write_filler(logic [31:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      filler_model = value;
   endtask

   task automatic add_row(logic [31:0] w, logic last, bit typed = 0,
                          coded_item_type item = '0);
      stim_row_type row;
      row.word  = w;
      row.last  = last;
      row.typed = typed;
      row.item  = item;
      directed_rows.push_back(row);
   endtask

   function automatic logic [31:0] pick_word(run_kind_type kind);
      case (kind)
         RUN_ZERO:    return 32'd0;
         RUN_FILLER:  return filler_model;
         RUN_LITERAL: begin
            // Near-misses of the filler and single set bits stress the comparators
            case ($urandom_range(3))
               0:       return filler_model ^ (32'h1 << $urandom_range(31));
               1:       return 32'h1 << $urandom_range(31);
               default: return $urandom();
            endcase
         end
         default: begin
            case ($urandom_range(2))
               0:       return 32'd0;
               1:       return filler_model;
               default: return $urandom();
            endcase
         end
      endcase
   endfunction

   task automatic send_run(run_kind_type kind, int len, bit ends_stream);
      for (int i = 0; i < len; i++)
         send_word(pick_word(kind), ends_stream && (i == len - 1));
   endtask

   // A stream is a few runs of random class and length ending on a last word;
   // a forced run, when given, lands at a random place among them.
   task automatic send_stream(run_kind_type forced_kind, int forced_len);
      int           total;
      int           forced_at;
      run_kind_type kind;
      int           len;
      total     = $urandom_range(1, 5) + ((forced_len > 0) ? 1 : 0);
      forced_at = (forced_len > 0) ? $urandom_range(0, total - 1) : -1;
      for (int r = 0; r < total; r++) begin
         if (r == forced_at) begin
            kind = forced_kind;
            len  = forced_len;
         end else begin
            case ($urandom_range(9))
               0, 1, 2: kind = RUN_ZERO;
               3, 4, 5: kind = RUN_FILLER;
               6, 7, 8: kind = RUN_LITERAL;
               default: kind = RUN_MIXED;
            endcase
            len = ($urandom_range(7) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
         end
         send_run(kind, len, r == total - 1);
         // Now and then let the pipe run dry with a run still open
         if (r != total - 1 && $urandom_range(11) == 0) drain_results();
      end
   endtask

   // Give up long after the slowest correct run would have finished
   initial begin
      #2_000_000;
      $display("word_run_length_encoder_tb NOT OK");
      $finish;
   end

   initial begin
      logic [31:0]  phase_filler [PHASES];
      run_kind_type phase_kind   [PHASES];
      int           phase_len    [PHASES];
      int           base;

      clock        = 1'b0;
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = 32'd0;
      req_tvalid   = 1'b0;
      req_tdata    = 32'd0;
      req_tlast    = 1'b0;
      rsp_tready   = 1'b0;
      failures     = 0;
      items_sent   = 0;
      steady       = 0;
      filler_model = wrle_pkg::FILLER_RESET;
      run_active   = 0;
      run_code_now = 8'd0;

      // Directed table, filler at its reset value. Typed rows are single
      // runs closed by a last word; the others go through the model.
      add_row(32'h0000_0000, 1'b1, 1, lone_run(wrle_pkg::ZERO_FIRST, 3'd0, 32'd0));
      add_row(wrle_pkg::FILLER_RESET, 1'b1, 1,
              lone_run(wrle_pkg::FILL_FIRST, 3'd0, 32'd0));
      add_row(32'hFFFF_FFFF, 1'b1, 1,
              lone_run(wrle_pkg::LIT_FIRST, 3'd1, 32'hFFFF_FFFF));
      // five literals: a full group then a single-word group
      add_row(32'h0000_0001, 1'b0);
      add_row(32'h8000_0000, 1'b0);
      add_row(32'h7FFF_FFFF, 1'b0);
      add_row(wrle_pkg::FILLER_RESET ^ 32'h1, 1'b0);
      add_row(32'hFFFF_FFFE, 1'b1);
      // zero run closed by filler words, filler run closed by a last zero word
      add_row(32'h0000_0000, 1'b0);
      add_row(32'h0000_0000, 1'b0);
      add_row(wrle_pkg::FILLER_RESET, 1'b0);
      add_row(wrle_pkg::FILLER_RESET, 1'b0);
      add_row(32'h0000_0000, 1'b1);
      // class change on the last word: old run and new one-word run together
      add_row(wrle_pkg::FILLER_RESET, 1'b0);
      add_row(32'h1234_5678, 1'b1);
      add_row(32'hA5A5_A5A5, 1'b0);
      add_row(32'h5A5A_5A5A, 1'b0);
      add_row(32'h0000_0000, 1'b0);
      add_row(32'hFFFF_FFFF, 1'b1);
      add_row(32'h0000_0000, 1'b0);
      add_row(32'h0000_0000, 1'b1);
      // exactly one group of four
      add_row(32'h3C3C_3C3C, 1'b0);
      add_row(32'hC3C3_C3C3, 1'b0);
      add_row(32'h0F0F_0F0F, 1'b0);
      add_row(32'hF0F0_F0F0, 1'b1);

      // Each phase pairs a filler setting with one run driven to or past its limit;
      // with the filler at zero, filler words fall into the zero class.
      phase_filler = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom(), wrle_pkg::FILLER_RESET};
      phase_kind   = '{RUN_ZERO, RUN_FILLER, RUN_LITERAL, RUN_FILLER};
      phase_len    = '{106, 24, LITERAL_RUN_MAX + 1, 23};

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_word(directed_rows[i].word, directed_rows[i].last,
                   directed_rows[i].typed, directed_rows[i].item);

      for (int p = 0; p < PHASES; p++) begin
         // Idle before touching the filler: every item in, flush pipe settled
         drain_results();
         repeat (8) @(posedge clock);
         write_filler(phase_filler[p]);
         steady = (p == 2);
         base   = items_sent;
         send_stream(phase_kind[p], phase_len[p]);
         while (items_sent - base < PHASE_ITEMS)
            send_stream(RUN_MIXED, 0);
      end
      steady = 0;

      drain_results();
      repeat (20) @(posedge clock);
      if (failures == 0)
         $display("word_run_length_encoder_tb OK");
      else
         $display("word_run_length_encoder_tb NOT OK");
      $finish;
   end

endmodule

// ----- word_run_length_encoder.f -----
rtl/core/wrle_pkg.sv
rtl/core/wrle_ram.sv
rtl/core/wrle_ctrl.sv
rtl/core/wrle_dpath.sv
rtl/core/word_run_length_encoder.sv
tb/sv/word_run_length_encoder_tb.sv
